>>> rtl/core/ufr_pkg.sv
// Shared types and constants for the UART frame receiver with XOR check.
`timescale 1ns / 1ps

package ufr_pkg;

	localparam int unsigned LEN_W  = 7;
	localparam int unsigned BYTE_W = 8;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 7'd64;

	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_MAX_LENGTH   = 1'b1;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_LOSS = 1'b1
	} kind_t;

	typedef enum logic {
		CAUSE_LENGTH   = 1'b0,
		CAUSE_CHECKSUM = 1'b1
	} cause_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_CHECK = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_FETCH = 3'b010,
		BK_EMIT  = 3'b100
	} back_state_t;

	typedef struct packed {
		kind_t            kind;
		cause_t           cause;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [LEN_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} buf_wr_t;

	typedef struct packed {
		logic q_full;
		logic q_empty;
		logic back_busy;
	} stall_t;

endpackage

>>> rtl/core/ufr_front.sv
// Front end: configuration, frame parser and payload buffer writes.
`timescale 1ns / 1ps

module ufr_front #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ufr_pkg::BYTE_W-1:0] cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic [ufr_pkg::BYTE_W-1:0] rx_byte,
	input  ufr_pkg::stall_t            stall,
	output logic                       cmd_push,
	output ufr_pkg::cmd_t              cmd,
	output ufr_pkg::buf_wr_t           buf_wr
);

	localparam logic [ufr_pkg::BYTE_W-1:0] MAX_PAYLOAD_B = ufr_pkg::BYTE_W'(MAX_PAYLOAD);

	logic [ufr_pkg::BYTE_W-1:0] start_marker_q;
	logic [ufr_pkg::LEN_W-1:0]  max_length_q;
	ufr_pkg::phase_t            phase_q;
	logic [ufr_pkg::LEN_W-1:0]  frame_length_q;
	logic [ufr_pkg::LEN_W-1:0]  byte_position_q;
	logic [ufr_pkg::BYTE_W-1:0] running_check_q;

	logic                       accept;
	logic                       len_bad;
	logic [ufr_pkg::LEN_W-1:0]  pos_next;

	assign full = stall.q_full
		|| (phase_q == ufr_pkg::PH_DATA && (!stall.q_empty || stall.back_busy));
	assign accept   = push && !full;
	assign len_bad  = (rx_byte == '0) || (rx_byte > {1'b0, max_length_q})
		|| (rx_byte > MAX_PAYLOAD_B);
	assign pos_next = byte_position_q + ufr_pkg::LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= ufr_pkg::START_MARKER_RST;
			max_length_q   <= ufr_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ufr_pkg::CFG_START_MARKER: start_marker_q <= cfg_wdata;
				ufr_pkg::CFG_MAX_LENGTH:   max_length_q   <= cfg_wdata[ufr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd_push    = 1'b0;
		cmd.kind    = ufr_pkg::KIND_LOSS;
		cmd.cause   = ufr_pkg::CAUSE_LENGTH;
		cmd.len     = frame_length_q;
		buf_wr.en   = 1'b0;
		buf_wr.addr = byte_position_q;
		buf_wr.data = rx_byte;
		if (accept) begin
			unique case (phase_q)
				ufr_pkg::PH_LEN: begin
					cmd_push = len_bad;
				end
				ufr_pkg::PH_DATA: begin
					buf_wr.en = 1'b1;
				end
				ufr_pkg::PH_CHECK: begin
					cmd_push  = 1'b1;
					cmd.cause = ufr_pkg::CAUSE_CHECKSUM;
					if (rx_byte == running_check_q) begin
						cmd.kind = ufr_pkg::KIND_DATA;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= ufr_pkg::PH_START;
			frame_length_q  <= '0;
			byte_position_q <= '0;
			running_check_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				ufr_pkg::PH_START: begin
					if (rx_byte == start_marker_q) begin
						phase_q         <= ufr_pkg::PH_LEN;
						running_check_q <= rx_byte;
					end
				end
				ufr_pkg::PH_LEN: begin
					if (len_bad) begin
						phase_q         <= ufr_pkg::PH_START;
						frame_length_q  <= '0;
						byte_position_q <= '0;
						running_check_q <= '0;
					end else begin
						phase_q         <= ufr_pkg::PH_DATA;
						frame_length_q  <= rx_byte[ufr_pkg::LEN_W-1:0];
						byte_position_q <= '0;
						running_check_q <= running_check_q ^ rx_byte;
					end
				end
				ufr_pkg::PH_DATA: begin
					running_check_q <= running_check_q ^ rx_byte;
					byte_position_q <= pos_next;
					if (pos_next >= frame_length_q) begin
						phase_q <= ufr_pkg::PH_CHECK;
					end
				end
				default: begin
					phase_q         <= ufr_pkg::PH_START;
					frame_length_q  <= '0;
					byte_position_q <= '0;
					running_check_q <= '0;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/ufr_cmd_queue.sv
// Two-entry command queue between the frame parser and the result sequencer.
`timescale 1ns / 1ps

module ufr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ufr_pkg::cmd_t wr_cmd,
	input  logic          rd_en,
	output ufr_pkg::cmd_t rd_cmd,
	output logic          q_full,
	output logic          q_empty
);

	ufr_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/ufr_back.sv
// Back end: payload buffer and result sequencer with output register.
`timescale 1ns / 1ps

module ufr_back #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ufr_pkg::buf_wr_t           buf_wr,
	input  ufr_pkg::cmd_t              cmd,
	input  logic                       cmd_valid,
	output logic                       cmd_pop,
	output logic                       back_busy,
	output logic                       empty,
	input  logic                       pop,
	output logic                       out_kind,
	output logic [ufr_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last,
	output logic                       loss_cause
);

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [ufr_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
	logic [ufr_pkg::BYTE_W-1:0] rd_data_q;
	logic [AW-1:0]              rd_idx_q;
	logic [ufr_pkg::LEN_W-1:0]  len_q;
	ufr_pkg::back_state_t       state_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       out_load;
	logic                       rd_en;
	logic                       is_last;

	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign back_busy = (state_q != ufr_pkg::BK_IDLE);
	assign rd_en     = (state_q == ufr_pkg::BK_FETCH);
	assign is_last   = (ufr_pkg::LEN_W'(rd_idx_q) + ufr_pkg::LEN_W'(1)) == len_q;
	assign cmd_pop   = (state_q == ufr_pkg::BK_IDLE) && cmd_valid
		&& (cmd.kind == ufr_pkg::KIND_DATA || out_free);
	assign out_load  = (state_q == ufr_pkg::BK_IDLE && cmd_pop
		&& cmd.kind == ufr_pkg::KIND_LOSS)
		|| (state_q == ufr_pkg::BK_EMIT && out_free);

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ufr_pkg::BK_IDLE;
			rd_idx_q    <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ufr_pkg::BK_IDLE: begin
					if (cmd_pop && cmd.kind == ufr_pkg::KIND_DATA) begin
						state_q  <= ufr_pkg::BK_FETCH;
						rd_idx_q <= '0;
						len_q    <= cmd.len;
					end
				end
				ufr_pkg::BK_FETCH: begin
					state_q <= ufr_pkg::BK_EMIT;
				end
				ufr_pkg::BK_EMIT: begin
					if (out_free) begin
						if (is_last) begin
							state_q <= ufr_pkg::BK_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
							state_q  <= ufr_pkg::BK_FETCH;
						end
					end
				end
				default: begin
					state_q <= ufr_pkg::BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ufr_pkg::BK_IDLE && cmd_pop && cmd.kind == ufr_pkg::KIND_LOSS) begin
			out_kind   <= ufr_pkg::KIND_LOSS;
			out_byte   <= '0;
			out_last   <= 1'b1;
			loss_cause <= cmd.cause;
		end else if (state_q == ufr_pkg::BK_EMIT && out_free) begin
			out_kind   <= ufr_pkg::KIND_DATA;
			out_byte   <= rd_data_q;
			out_last   <= is_last;
			loss_cause <= ufr_pkg::CAUSE_LENGTH;
		end
	end

endmodule

>>> rtl/core/uart_frame_receiver_xor_check.sv
// Top level of the UART frame receiver with XOR checksum.
// Path: a loss result passes the command queue, then the output register; the first
// payload result passes the queue, sequencer state, buffer read and output register.
// Throughput: one byte per cycle outside payload while the command queue is not full;
// a good frame then drains each result through a buffer read and the output register,
// and full holds payload bytes of the next frame until that drain ends.
// Reset: arst_n clears all control state and loads the default registers; no sweep.
`timescale 1ns / 1ps

module uart_frame_receiver_xor_check #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ufr_pkg::BYTE_W-1:0] cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic [ufr_pkg::BYTE_W-1:0] rx_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic                       out_kind,
	output logic [ufr_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last,
	output logic                       loss_cause
);

	ufr_pkg::stall_t  stall;
	ufr_pkg::cmd_t    wr_cmd;
	ufr_pkg::cmd_t    rd_cmd;
	ufr_pkg::buf_wr_t buf_wr;
	logic             cmd_push;
	logic             cmd_pop;
	logic             q_full;
	logic             q_empty;
	logic             back_busy;

	assign stall.q_full    = q_full;
	assign stall.q_empty   = q_empty;
	assign stall.back_busy = back_busy;

	ufr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.rx_byte  (rx_byte),
		.stall    (stall),
		.cmd_push (cmd_push),
		.cmd      (wr_cmd),
		.buf_wr   (buf_wr)
	);

	ufr_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (wr_cmd),
		.rd_en  (cmd_pop),
		.rd_cmd (rd_cmd),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	ufr_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.buf_wr    (buf_wr),
		.cmd       (rd_cmd),
		.cmd_valid (!q_empty),
		.cmd_pop   (cmd_pop),
		.back_busy (back_busy),
		.empty     (empty),
		.pop       (pop),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.loss_cause(loss_cause)
	);

endmodule

>>> dv/uart_frame_receiver_xor_check_tb.sv
// Self-checking testbench for the UART frame receiver with XOR checksum.
`timescale 1ns / 1ps

module uart_frame_receiver_xor_check_tb;

	localparam int MAX_PAYLOAD   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [ufr_pkg::BYTE_W-1:0] value;
		bit                         hold;
	} rx_item_t;

	typedef struct {
		ufr_pkg::kind_t             kind;
		logic [ufr_pkg::BYTE_W-1:0] data;
		logic                       last;
		ufr_pkg::cause_t            cause;
	} frame_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_index = ufr_pkg::CFG_START_MARKER;
	logic [ufr_pkg::BYTE_W-1:0] cfg_wdata = '0;
	logic                       push = 1'b0;
	logic                       full;
	logic [ufr_pkg::BYTE_W-1:0] rx_byte = '0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic                       out_kind;
	logic [ufr_pkg::BYTE_W-1:0] out_byte;
	logic                       out_last;
	logic                       loss_cause;

	rx_item_t      rx_stream[$];
	frame_result_t results_due[$];

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int mismatches      = 0;
	int cycle_count     = 0;

	logic [ufr_pkg::BYTE_W-1:0] cfg_marker = ufr_pkg::START_MARKER_RST;
	logic [ufr_pkg::LEN_W-1:0]  cfg_maxlen = ufr_pkg::MAX_LENGTH_RST;

	ufr_pkg::phase_t            fr_phase = ufr_pkg::PH_START;
	logic [ufr_pkg::LEN_W-1:0]  fr_len   = '0;
	logic [ufr_pkg::LEN_W-1:0]  fr_pos   = '0;
	logic [ufr_pkg::BYTE_W-1:0] fr_check = '0;
	logic [ufr_pkg::BYTE_W-1:0] fr_store[MAX_PAYLOAD];

	uart_frame_receiver_xor_check #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.loss_cause (loss_cause)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic clear_frame();
		fr_phase = ufr_pkg::PH_START;
		fr_len   = '0;
		fr_pos   = '0;
		fr_check = '0;
	endtask

	task automatic expect_loss(input ufr_pkg::cause_t c);
		frame_result_t r;
		r.kind  = ufr_pkg::KIND_LOSS;
		r.data  = '0;
		r.last  = 1'b1;
		r.cause = c;
		results_due.push_back(r);
	endtask

	task automatic deframe_byte(input logic [ufr_pkg::BYTE_W-1:0] b);
		frame_result_t r;
		int k;
		case (fr_phase)
			ufr_pkg::PH_START: begin
				if (b == cfg_marker) begin
					fr_phase = ufr_pkg::PH_LEN;
					fr_check = b;
				end
			end
			ufr_pkg::PH_LEN: begin
				if (b == 8'd0 || b > {1'b0, cfg_maxlen} || b > MAX_PAYLOAD) begin
					expect_loss(ufr_pkg::CAUSE_LENGTH);
					clear_frame();
				end else begin
					fr_len   = b[ufr_pkg::LEN_W-1:0];
					fr_pos   = '0;
					fr_check = fr_check ^ b;
					fr_phase = ufr_pkg::PH_DATA;
				end
			end
			ufr_pkg::PH_DATA: begin
				if (fr_pos < MAX_PAYLOAD) begin
					fr_store[fr_pos[5:0]] = b;
				end
				fr_check = fr_check ^ b;
				fr_pos   = fr_pos + 7'd1;
				if (fr_pos >= fr_len) begin
					fr_phase = ufr_pkg::PH_CHECK;
				end
			end
			ufr_pkg::PH_CHECK: begin
				if (b == fr_check) begin
					for (k = 0; k < fr_len; k++) begin
						r.kind  = ufr_pkg::KIND_DATA;
						r.data  = fr_store[k];
						r.last  = (k == fr_len - 1);
						r.cause = ufr_pkg::CAUSE_LENGTH;
						results_due.push_back(r);
					end
				end else begin
					expect_loss(ufr_pkg::CAUSE_CHECKSUM);
				end
				clear_frame();
			end
			default: begin
				clear_frame();
			end
		endcase
	endtask

	// drive one beat per accepted item; hold the next item while full
	always @(posedge clk) begin : drive_rx
		rx_item_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push) begin
				deframe_byte(rx_byte);
			end
			if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct
			    && !(rx_stream[0].hold && results_due.size() != 0)) begin
				nxt = rx_stream.pop_front();
				push    <= 1'b1;
				rx_byte <= nxt.value;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		frame_result_t exp_r;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] unexpected result: kind=%0d byte=%02h last=%0d cause=%0d",
							$realtime, out_kind, out_byte, out_last, loss_cause);
					end
				end else begin
					exp_r = results_due.pop_front();
					if (out_kind !== exp_r.kind || out_byte !== exp_r.data
					    || out_last !== exp_r.last || loss_cause !== exp_r.cause) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] result mismatch: expected kind=%0d byte=%02h last=%0d cause=%0d",
								$realtime, exp_r.kind, exp_r.data, exp_r.last, exp_r.cause);
							$display("[%0t]                  got kind=%0d byte=%02h last=%0d cause=%0d",
								$realtime, out_kind, out_byte, out_last, loss_cause);
						end
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("uart_frame_receiver_xor_check verification failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [ufr_pkg::BYTE_W-1:0] b, input bit hold = 1'b0);
		rx_item_t it;
		it.value = b;
		it.hold  = hold;
		rx_stream.push_back(it);
	endtask

	function automatic int eff_max();
		return (cfg_maxlen > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_maxlen);
	endfunction

	task automatic queue_bad_length();
		queue_byte(cfg_marker);
		if ($urandom_range(3) == 0) begin
			queue_byte(8'd0);
		end else begin
			queue_byte(8'($urandom_range(255, eff_max() + 1)));
		end
	endtask

	task automatic queue_frame(input int len, input bit bad_sum, input bit hold);
		logic [ufr_pkg::BYTE_W-1:0] sum;
		logic [ufr_pkg::BYTE_W-1:0] pb;
		int i;
		sum = cfg_marker ^ 8'(len);
		queue_byte(cfg_marker, hold);
		queue_byte(8'(len));
		for (i = 0; i < len; i++) begin
			pb = ($urandom_range(15) == 0) ? cfg_marker : 8'($urandom_range(255));
			sum = sum ^ pb;
			queue_byte(pb);
		end
		if (bad_sum) begin
			sum = sum ^ 8'($urandom_range(255, 1));
		end
		queue_byte(sum);
	endtask

	task automatic queue_traffic(input int n);
		int target;
		int pick;
		int len;
		target = rx_stream.size() + n;
		while (rx_stream.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				queue_byte(8'($urandom_range(255)));
			end else if (pick < 16 || eff_max() == 0) begin
				queue_bad_length();
			end else begin
				if ($urandom_range(19) == 0) begin
					len = $urandom_range(eff_max(), 1);
				end else begin
					len = $urandom_range((eff_max() < 8) ? eff_max() : 8, 1);
				end
				queue_frame(len, pick < 26, 1'b0);
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [ufr_pkg::BYTE_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ufr_pkg::CFG_START_MARKER) begin
			cfg_marker = data;
		end else begin
			cfg_maxlen = data[ufr_pkg::LEN_W-1:0];
		end
	endtask

	task automatic drain_and_settle();
		while (rx_stream.size() != 0 || push) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, both loss causes, marker inside a frame
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'hAA);
		queue_byte(8'd0);
		queue_byte(8'hAA);
		queue_byte(8'd65);
		queue_byte(8'hAA);
		queue_byte(8'd1);
		queue_byte(8'hFF);
		queue_byte(8'hAA ^ 8'd1 ^ 8'hFF);
		queue_byte(8'hAA);
		queue_byte(8'd1);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'hAA);
		queue_byte(8'd2);
		queue_byte(8'hAA);
		queue_byte(8'h55);
		queue_byte(8'hAA ^ 8'd2 ^ 8'hAA ^ 8'h55);
		queue_byte(8'hAA);
		queue_byte(8'd255);
		drain_and_settle();

		queue_traffic(10);
		queue_frame(MAX_PAYLOAD, 1'b0, 1'b1);
		queue_traffic(10);
		drain_and_settle();

		write_reg(ufr_pkg::CFG_START_MARKER, 8'h00);
		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'd1);
		sender_idle_pct = 55;
		queue_traffic(20);
		drain_and_settle();

		write_reg(ufr_pkg::CFG_START_MARKER, 8'hFF);
		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'hFF);
		sender_idle_pct = 0;
		recv_stall_pct  = 55;
		queue_frame(MAX_PAYLOAD, 1'b0, 1'b0);
		queue_byte(cfg_marker);
		queue_byte(8'd127);
		queue_traffic(15);
		drain_and_settle();

		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'd0);
		write_reg(ufr_pkg::CFG_START_MARKER, 8'($urandom_range(255)));
		sender_idle_pct = 36;
		recv_stall_pct  = 36;
		queue_traffic(8);
		drain_and_settle();

		// register writes while a frame is open
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		write_reg(ufr_pkg::CFG_START_MARKER, 8'hAA);
		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'd64);
		queue_byte(8'hAA);
		drain_and_settle();
		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'd2);
		queue_byte(8'd3);
		queue_byte(8'hAA);
		queue_byte(8'd2);
		drain_and_settle();
		write_reg(ufr_pkg::CFG_START_MARKER, 8'h5A);
		queue_byte(8'h11);
		queue_byte(8'h5A);
		queue_byte(8'hAA ^ 8'd2 ^ 8'h11 ^ 8'h5A);
		drain_and_settle();

		write_reg(ufr_pkg::CFG_START_MARKER, 8'($urandom_range(255)));
		write_reg(ufr_pkg::CFG_MAX_LENGTH, 8'($urandom_range(127, 1)));
		sender_idle_pct = 36;
		recv_stall_pct  = 36;
		queue_traffic(20);
		drain_and_settle();

		if (mismatches == 0) begin
			$display("uart_frame_receiver_xor_check verification clean");
		end else begin
			$display("uart_frame_receiver_xor_check verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/ufr_pkg.sv
rtl/core/ufr_front.sv
rtl/core/ufr_cmd_queue.sv
rtl/core/ufr_back.sv
rtl/core/uart_frame_receiver_xor_check.sv
dv/uart_frame_receiver_xor_check_tb.sv
